// ----- design/text_console_writer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shorthand for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, codes and helpers of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CHAR_W = 8;
    localparam int COLOR_W = 4;
    localparam int CELL_W = 16;
    localparam int FUNC_W = 2;
    localparam int CFG_INDEX_W = 4;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR = 4'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;

    typedef struct packed {
        logic write_char;
        logic scroll;
    } tcw_put_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg,
        input logic [CHAR_W-1:0]  ch
    );
        make_cell = {bg, fg, ch};
    endfunction

endpackage

// ----- design/tcw_cursor.sv -----
// ----------------------------------------------------------------------------
// Text console writer cursor
// Holds the cursor, works out its move for a put-character transfer and homes it on request.
// ----------------------------------------------------------------------------
module tcw_cursor #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ROW_W   = $clog2(ROWS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      put_en,
    input  logic                      home_en,
    input  logic [tcw_pkg::CHAR_W-1:0] char_code,
    output logic [ROW_W-1:0]          row,
    output logic [COL_W-1:0]          col,
    output tcw_pkg::tcw_put_t         put_info
);
    import tcw_pkg::*;

    localparam int NCOL_W = COL_W + 1;
    localparam int NROW_W = ROW_W + 1;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [NCOL_W-1:0] col_calc;
    logic [NROW_W-1:0] row_calc;

    always_comb begin
        put_info = '0;
        row_calc = {1'b0, row_reg};
        case (char_code)
            CH_NEWLINE: begin
                col_calc = '0;
                row_calc = row_calc + NROW_W'(1);
            end
            CH_RETURN: begin
                col_calc = '0;
            end
            CH_TAB: begin
                col_calc = ({1'b0, col_reg} + NCOL_W'(4)) & ~NCOL_W'(3);
            end
            default: begin
                col_calc = {1'b0, col_reg} + NCOL_W'(1);
                put_info.write_char = 1'b1;
            end
        endcase
        if (int'(col_calc) >= COLUMNS) begin
            col_calc = '0;
            row_calc = row_calc + NROW_W'(1);
        end
        if (int'(row_calc) >= ROWS) begin
            put_info.scroll = 1'b1;
            row_calc = NROW_W'(ROWS - 1);
        end
    end

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (home_en) begin
            row_next = '0;
            col_next = '0;
        end else if (put_en) begin
            row_next = row_calc[ROW_W-1:0];
            col_next = col_calc[COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign row = row_reg;
    assign col = col_reg;

endmodule

// ----- design/tcw_screen_ram.sv -----
// ----------------------------------------------------------------------------
// Text console writer screen memory
// Cell store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] ram_reg [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/text_console_writer_unit.sv -----
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode screen engine with a cell memory, a cursor and a scroll sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  s_        in         s_valid / s_ready       func, char_code, read_row, read_col
//  m_        out        m_valid / m_ready       read_cell, cursor_row, cursor_col, scrolled
//  cfg_      in         cfg_valid / cfg_ready   index, data (fg and bg colour)
//
//  For a put, read or unused item the transfer cycle does the memory access and the
//  cursor move; the result register loads in the done state once the output is free.
//  A put that scrolls copies the rows up through the single memory read port,
//  followed by the fill of the bottom row.
//  A clear makes one memory write per cell.
//  Reset clears the cursor and the control state and sets the colours to their reset
//  values; the cells stay undefined until the first clear. A stalled result holds in
//  its register while the next input transfer is taken.
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]     s_func,
    input  logic [7:0]                     s_char_code,
    input  logic [4:0]                     s_read_row,
    input  logic [6:0]                     s_read_col,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_read_cell,
    output logic [4:0]                     m_cursor_row,
    output logic [6:0]                     m_cursor_col,
    output logic                           m_scrolled,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]    cfg_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW_AT = ADDR_W'((ROWS - 1) * COLUMNS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCROLL = 4'b0010,
        ST_FILL   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              read_ok_reg, read_ok_next;
    logic              scrolled_reg, scrolled_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;

    logic              m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] m_read_cell_reg, m_read_cell_next;
    logic [4:0]        m_cursor_row_reg, m_cursor_row_next;
    logic [6:0]        m_cursor_col_reg, m_cursor_col_next;
    logic              m_scrolled_reg, m_scrolled_next;

    logic              accept;
    logic              load_result;
    logic              read_in_range;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] read_addr;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    tcw_put_t          put_info;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign cursor_addr   = ADDR_W'(32'(cur_row) * COLUMNS + 32'(cur_col));
    assign read_addr     = ADDR_W'(32'(s_read_row) * COLUMNS + 32'(s_read_col));
    assign read_in_range = (int'(s_read_row) < ROWS) && (int'(s_read_col) < COLUMNS);
    assign load_result   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .COL_W   (COL_W),
        .ROW_W   (ROW_W)
    ) u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .put_en    (accept && (s_func == FUNC_PUT)),
        .home_en   (accept && (s_func == FUNC_CLEAR)),
        .char_code (s_char_code),
        .row       (cur_row),
        .col       (cur_col),
        .put_info  (put_info)
    );

    tcw_screen_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_screen_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        fill_next      = fill_reg;
        pend_next      = 1'b0;
        pend_addr_next = scan_reg - ROW_STRIDE;
        read_ok_next   = read_ok_reg;
        scrolled_next  = scrolled_reg;
        wr_en          = 1'b0;
        wr_addr        = cursor_addr;
        wr_data        = make_cell(fg_reg, bg_reg, s_char_code);
        rd_en          = 1'b0;
        rd_addr        = read_addr;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    read_ok_next  = 1'b0;
                    scrolled_next = 1'b0;
                    state_next    = ST_DONE;
                    case (s_func)
                        FUNC_PUT: begin
                            wr_en         = put_info.write_char;
                            scrolled_next = put_info.scroll;
                            scan_next     = ROW_STRIDE;
                            if (put_info.scroll) begin
                                state_next = ST_SCROLL;
                            end
                        end
                        FUNC_CLEAR: begin
                            fill_next  = '0;
                            state_next = ST_FILL;
                        end
                        FUNC_READ: begin
                            rd_en        = read_in_range;
                            read_ok_next = read_in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                rd_en     = 1'b1;
                rd_addr   = scan_reg;
                pend_next = 1'b1;
                wr_en     = pend_reg;
                wr_addr   = pend_addr_reg;
                wr_data   = rd_data;
                scan_next = scan_reg + ADDR_W'(1);
                if (scan_reg == LAST_ADDR) begin
                    fill_next  = BOTTOM_ROW_AT;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                wr_en = 1'b1;
                if (pend_reg) begin
                    wr_addr = pend_addr_reg;
                    wr_data = rd_data;
                end else begin
                    wr_addr   = fill_reg;
                    wr_data   = make_cell(fg_reg, bg_reg, CH_BLANK);
                    fill_next = fill_reg + ADDR_W'(1);
                    if (fill_reg == LAST_ADDR) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (load_result) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FG_COLOR) begin
                fg_next = cfg_data;
            end else if (cfg_index == REG_BG_COLOR) begin
                bg_next = cfg_data;
            end
        end
    end

    always_comb begin
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_cell_next  = m_read_cell_reg;
        m_cursor_row_next = m_cursor_row_reg;
        m_cursor_col_next = m_cursor_col_reg;
        m_scrolled_next   = m_scrolled_reg;
        if (load_result) begin
            m_valid_next      = 1'b1;
            m_read_cell_next  = read_ok_reg ? rd_data : '0;
            m_cursor_row_next = 5'(cur_row);
            m_cursor_col_next = 7'(cur_col);
            m_scrolled_next   = scrolled_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            fg_reg      <= FG_RESET;
            bg_reg      <= BG_RESET;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg         <= scan_next;
        fill_reg         <= fill_next;
        pend_addr_reg    <= pend_addr_next;
        read_ok_reg      <= read_ok_next;
        scrolled_reg     <= scrolled_next;
        m_read_cell_reg  <= m_read_cell_next;
        m_cursor_row_reg <= m_cursor_row_next;
        m_cursor_col_reg <= m_cursor_col_next;
        m_scrolled_reg   <= m_scrolled_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_cell  = m_read_cell_reg;
    assign m_cursor_row = m_cursor_row_reg;
    assign m_cursor_col = m_cursor_col_reg;
    assign m_scrolled   = m_scrolled_reg;

endmodule

// ----- design/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on the text console writer, attached by bind.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_macros.svh"

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [15:0]                     m_read_cell,
    input logic [4:0]                      m_cursor_row,
    input logic [6:0]                      m_cursor_col,
    input logic                            m_scrolled
);

    `TCW_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready, !s_ready, "input taken back to back")
    `TCW_ASSERT_NOW(a_col_in_range, m_valid, int'(m_cursor_col) < COLUMNS, "cursor column out of range")
    `TCW_ASSERT_NOW(a_scroll_bottom, m_valid && m_scrolled, m_cursor_row == 5'(ROWS - 1), "scroll left cursor off bottom row")
    `TCW_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_read_cell) && $stable(m_cursor_col), "stalled result changed")

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);
